// File: src/dtlb_pkg.sv
// dtlb_pkg: shared constants, codes and types of the data tlb translate unit
// no dependencies; used by the interfaces, the entry ram, the check logic and the top level

package dtlb_pkg;

  // sizes of the translation buffer and the address space
  // TLB_ENTRIES is a power of two: the slot is the low page-number bits
  localparam int TLB_ENTRIES = 64;
  localparam int PAGE_SHIFT  = 13;
  localparam int ADDR_WIDTH  = 32;
  localparam int IDX_W       = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int VPN_W       = ADDR_WIDTH - PAGE_SHIFT;

  // fixed field widths of the entry write
  localparam int ENTRY_IDX_W = 6;
  localparam int TAG_W       = 19;
  localparam int PPN_W       = 19;
  localparam int PERM_W      = 4;

  // permission bit positions, indexed by {supervisor, is_store}
  localparam int PERM_UR_BIT = 0;
  localparam int PERM_UW_BIT = 1;
  localparam int PERM_SR_BIT = 2;
  localparam int PERM_SW_BIT = 3;

  typedef enum logic {
    FUNC_TRANSLATE = 1'b0,
    FUNC_WRITE     = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_MISS  = 2'd1,
    ST_FAULT = 2'd2
  } status_e;

  // one stored entry, valid bit kept apart in flops
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [PPN_W-1:0]  page;
    logic [PERM_W-1:0] perm;
  } entry_t;

  // translate request as held while the entry is read
  typedef struct packed {
    func_e                 func;
    logic [ADDR_WIDTH-1:0] vaddr;
    logic                  is_store;
    logic                  supervisor;
  } req_info_t;

  typedef struct packed {
    logic [ADDR_WIDTH-1:0] paddr;
    status_e               status;
    logic [ADDR_WIDTH-1:0] fault_vaddr;
  } result_t;

endpackage

// File: src/dtlb_if.sv
// dtlb_req_if / dtlb_rsp_if: valid/ready channels of the data tlb translate unit
// depends on dtlb_pkg

interface dtlb_req_if;
  logic                            valid;
  logic                            ready;
  dtlb_pkg::func_e                 func;
  logic [dtlb_pkg::ADDR_WIDTH-1:0] vaddr;
  logic                            is_store;
  logic                            supervisor;
  logic [dtlb_pkg::ENTRY_IDX_W-1:0] entry_index;
  logic                            entry_valid;
  logic [dtlb_pkg::TAG_W-1:0]      entry_vpn;
  logic [dtlb_pkg::PPN_W-1:0]      entry_ppn;
  logic [dtlb_pkg::PERM_W-1:0]     entry_perms;

  modport source (
    output valid, func, vaddr, is_store, supervisor,
           entry_index, entry_valid, entry_vpn, entry_ppn, entry_perms,
    input  ready
  );
  modport sink (
    input  valid, func, vaddr, is_store, supervisor,
           entry_index, entry_valid, entry_vpn, entry_ppn, entry_perms,
    output ready
  );
endinterface

interface dtlb_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [dtlb_pkg::ADDR_WIDTH-1:0] paddr;
  dtlb_pkg::status_e               status;
  logic [dtlb_pkg::ADDR_WIDTH-1:0] fault_vaddr;

  modport source (
    output valid, paddr, status, fault_vaddr,
    input  ready
  );
  modport sink (
    input  valid, paddr, status, fault_vaddr,
    output ready
  );
endinterface

// File: src/dtlb_ram.sv
// dtlb_ram: entry store (tag, page, permissions), one write and one read port
// depends on dtlb_pkg; read data is registered

module dtlb_ram (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [dtlb_pkg::IDX_W-1:0] waddr_i,
  input  dtlb_pkg::entry_t           wdata_i,
  input  logic                       re_i,
  input  logic [dtlb_pkg::IDX_W-1:0] raddr_i,
  output dtlb_pkg::entry_t           rdata_o
);

  dtlb_pkg::entry_t mem_q [dtlb_pkg::TLB_ENTRIES];
  dtlb_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/dtlb_check.sv
// dtlb_check: tag compare, permission check and physical address forming
// depends on dtlb_pkg; purely combinational, fed by the read stage of the top level

module dtlb_check (
  input  logic                mmu_enable_i,
  input  dtlb_pkg::req_info_t req_i,
  input  logic                slot_valid_i,
  input  dtlb_pkg::entry_t    entry_i,
  output dtlb_pkg::result_t   result_o
);

  logic [dtlb_pkg::ADDR_WIDTH-1:0] vpn_ext;
  logic [dtlb_pkg::ADDR_WIDTH-1:0] tag_ext;
  logic [1:0]                      perm_sel;
  logic                            hit;
  logic                            perm_ok;
  logic [dtlb_pkg::ADDR_WIDTH-1:0] pa;

  assign vpn_ext  = req_i.vaddr >> dtlb_pkg::PAGE_SHIFT;
  assign tag_ext  = dtlb_pkg::ADDR_WIDTH'(entry_i.tag);
  assign hit      = slot_valid_i && (tag_ext == vpn_ext);

  // {supervisor, is_store} picks user read/write or supervisor read/write
  assign perm_sel = {req_i.supervisor, req_i.is_store};
  assign perm_ok  = entry_i.perm[perm_sel];

  assign pa = (dtlb_pkg::ADDR_WIDTH'(entry_i.page) << dtlb_pkg::PAGE_SHIFT)
            | {{dtlb_pkg::VPN_W{1'b0}}, req_i.vaddr[dtlb_pkg::PAGE_SHIFT-1:0]};

  always_comb begin
    result_o.paddr       = '0;
    result_o.status      = dtlb_pkg::ST_OK;
    result_o.fault_vaddr = '0;
    if (req_i.func == dtlb_pkg::FUNC_TRANSLATE) begin
      if (!mmu_enable_i) begin
        result_o.paddr = req_i.vaddr;
      end else if (!hit) begin
        result_o.status      = dtlb_pkg::ST_MISS;
        result_o.fault_vaddr = req_i.vaddr;
      end else if (!perm_ok) begin
        result_o.status      = dtlb_pkg::ST_FAULT;
        result_o.fault_vaddr = req_i.vaddr;
      end else begin
        result_o.paddr = pa;
      end
    end
  end

endmodule

// File: src/data_tlb_translate_unit.sv
// data_tlb_translate_unit: data mmu with a direct-mapped tlb
// depends on dtlb_pkg, dtlb_if (dtlb_req_if, dtlb_rsp_if), dtlb_ram and dtlb_check
//
// usage
//   req carries one item per transfer: func selects translate or entry write.
//   an entry write loads slot entry_index (ignored when out of range) and
//   answers with an all-zero result. a translate returns the physical
//   address, a tlb miss or a page fault on rsp, one result per item.
//   cfg_we_i/cfg_wdata_i write mmu_enable; write it only while the unit is idle.
// timing
//   a req transfer goes first into the read stage, with the synchronous read of
//   the entry ram, and then through the check into the output register, which
//   drives rsp.valid. the ram port and the read stage take one item per cycle,
//   so throughput is one item per cycle while rsp.ready stays high.
// reset and stalls
//   reset clears the slot valid bits, mmu_enable and both pipeline stages;
//   the entry ram itself is not cleared. when rsp.ready is low the output
//   register holds, the read stage fills, and then req.ready drops.

module data_tlb_translate_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  dtlb_req_if.sink          req,
  dtlb_rsp_if.source        rsp
);

  // configuration
  logic mmu_enable_q;

  // slot valid bits live in flops so reset clears them at once
  logic [dtlb_pkg::TLB_ENTRIES-1:0] tlb_valid_q;

  // read stage: request waits here for the ram data
  logic                s1_valid_q;
  dtlb_pkg::req_info_t s1_q;
  logic                s1_slot_valid_q;

  // output register
  logic              out_valid_q;
  dtlb_pkg::result_t out_q;

  // handshake
  logic out_load;
  logic s1_adv;
  logic req_xfer;

  // slot addressing
  logic [dtlb_pkg::IDX_W-1:0] rd_slot;
  logic [dtlb_pkg::IDX_W-1:0] wr_slot;
  logic                       wr_in_range;
  logic                       tlb_we;
  logic                       tlb_re;

  dtlb_pkg::entry_t  wr_entry;
  dtlb_pkg::entry_t  rd_entry;
  dtlb_pkg::result_t s1_result;

  // output register frees up when empty or when its result is taken
  assign out_load  = !out_valid_q || rsp.ready;
  assign s1_adv    = s1_valid_q && out_load;
  assign req.ready = !s1_valid_q || out_load;
  assign req_xfer  = req.valid && req.ready;

  // slot is the low page-number bits
  assign rd_slot     = req.vaddr[dtlb_pkg::PAGE_SHIFT +: dtlb_pkg::IDX_W];
  assign wr_slot     = dtlb_pkg::IDX_W'(req.entry_index);
  assign wr_in_range = int'(req.entry_index) < dtlb_pkg::TLB_ENTRIES;

  // a write lands at the transfer edge, so the next translate transfer already reads it
  assign tlb_we = req_xfer && (req.func == dtlb_pkg::FUNC_WRITE) && wr_in_range;
  assign tlb_re = req_xfer && (req.func == dtlb_pkg::FUNC_TRANSLATE);

  assign wr_entry.tag  = req.entry_vpn;
  assign wr_entry.page = req.entry_ppn;
  assign wr_entry.perm = req.entry_perms;

  dtlb_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (tlb_we),
    .waddr_i (wr_slot),
    .wdata_i (wr_entry),
    .re_i    (tlb_re),
    .raddr_i (rd_slot),
    .rdata_o (rd_entry)
  );

  dtlb_check u_check (
    .mmu_enable_i (mmu_enable_q),
    .req_i        (s1_q),
    .slot_valid_i (s1_slot_valid_q),
    .entry_i      (rd_entry),
    .result_o     (s1_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mmu_enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      mmu_enable_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tlb_valid_q <= '0;
    end else if (tlb_we) begin
      tlb_valid_q[wr_slot] <= req.entry_valid;
    end
  end

  // read stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // read stage payload, valid bit sampled with the ram read
  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      s1_q.func        <= req.func;
      s1_q.vaddr       <= req.vaddr;
      s1_q.is_store    <= req.is_store;
      s1_q.supervisor  <= req.supervisor;
      s1_slot_valid_q  <= tlb_valid_q[rd_slot];
    end
  end

  // output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q <= s1_result;
    end
  end

  assign rsp.valid       = out_valid_q;
  assign rsp.paddr       = out_q.paddr;
  assign rsp.status      = out_q.status;
  assign rsp.fault_vaddr = out_q.fault_vaddr;

  // a stalled read stage keeps its request
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_load |=> s1_valid_q && $stable(s1_q))
    else $error("read stage lost or changed its request under stall");

  // entry writes answer with an all-zero result
  a_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && (s1_q.func == dtlb_pkg::FUNC_WRITE) |->
      (s1_result.paddr == '0) && (s1_result.fault_vaddr == '0) &&
      (s1_result.status == dtlb_pkg::ST_OK))
    else $error("entry write produced a non-zero result");

  // with translation off the address passes through
  a_bypass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !mmu_enable_q && (s1_q.func == dtlb_pkg::FUNC_TRANSLATE) |->
      (s1_result.paddr == s1_q.vaddr) && (s1_result.status == dtlb_pkg::ST_OK))
    else $error("bypass translation altered the address");

  // misses and faults report the virtual address and no physical one
  a_fault_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && (s1_result.status != dtlb_pkg::ST_OK) |->
      (s1_result.paddr == '0) && (s1_result.fault_vaddr == s1_q.vaddr))
    else $error("miss or fault reported with wrong addresses");

endmodule
